// ===== sv/rcrf_pkg.sv =====
package rcrf_pkg;

  localparam int CODE_BYTES_DEF     = 5;
  localparam int MIN_CODE_BYTES_DEF = 3;
  localparam int IN_BYTES           = 5;
  localparam int LEN_W              = 6;
  localparam int CFG_IDX_W          = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_MASK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIQUE_CODES  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_WINDOW = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REMOTE_KIND   = 2'd3;

  localparam logic [31:0] CHANNEL_MASK_RST  = 32'h0000_FFFF;
  localparam logic [15:0] REPEAT_WINDOW_RST = 16'd10;
  localparam logic        KIND_NIBBLE       = 1'b0;
  localparam logic        KIND_FIRST_BYTE   = 1'b1;
  localparam logic [7:0]  LOW_NIBBLE_MASK   = 8'h0F;

  typedef struct packed {
    logic             packet_ok;
    logic [LEN_W-1:0] byte_count;
    logic [7:0]       byte0;
    logic [7:0]       byte1;
    logic [7:0]       byte2;
    logic [7:0]       byte3;
    logic [7:0]       byte4;
    logic [31:0]      now;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte0;
    logic [7:0] out_byte1;
    logic [7:0] out_byte2;
    logic [7:0] out_byte3;
    logic [7:0] out_byte4;
    logic [7:0] channel;
  } out_item_t;

  // Controls shared by every byte lane for the current packet.
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             strip_nibble;
    logic             strip_first;
    logic [3:0]       chan_nibble;
  } lane_ctrl_t;

  typedef struct packed {
    logic emit;
    logic same;
  } merge_stat_t;

endpackage

// ===== sv/remote_code_channel_repeat_filter_unit.sv =====
// Output: a result is registered in the output buffer and shows on out_valid unless out_stall holds it.
// One packet per cycle while in_stall is low; all byte lanes and the merge are combinational.
// A two-entry output buffer lets a packet enter while one result waits on out_stall.
// Reset (rst_n low, synchronous) loads the register defaults, clears the stored
// code and stored time, and empties the output buffer.
module remote_code_channel_repeat_filter_unit #(
  parameter int CODE_BYTES     = rcrf_pkg::CODE_BYTES_DEF,
  parameter int MIN_CODE_BYTES = rcrf_pkg::MIN_CODE_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  rcrf_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output rcrf_pkg::out_item_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rcrf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                        cfg_wdata
);

  logic [31:0] channel_mask_r;
  logic        unique_codes_r;
  logic [15:0] repeat_window_r;
  logic        remote_kind_r;

  logic [7:0]  last_code_r [CODE_BYTES];
  logic [31:0] last_time_r;

  logic                  out_valid_r;
  rcrf_pkg::out_item_t   out_data_r;
  logic                  skid_valid_r;
  rcrf_pkg::out_item_t   skid_data_r;

  logic [7:0]            in_bytes [rcrf_pkg::IN_BYTES];
  logic [7:0]            raw [CODE_BYTES];
  logic [7:0]            wr_bytes [CODE_BYTES];
  logic [7:0]            next_code [CODE_BYTES];
  logic [7:0]            res_bytes [rcrf_pkg::IN_BYTES];
  logic [CODE_BYTES-1:0] lane_match;
  logic [7:0]            last_raw;
  logic [7:0]            chan;
  rcrf_pkg::lane_ctrl_t  ctrl;
  rcrf_pkg::merge_stat_t stat;
  rcrf_pkg::out_item_t   result;
  logic                  accept;
  logic                  res_valid;
  logic                  out_take;

  assign in_bytes[0] = in_data.byte0;
  assign in_bytes[1] = in_data.byte1;
  assign in_bytes[2] = in_data.byte2;
  assign in_bytes[3] = in_data.byte3;
  assign in_bytes[4] = in_data.byte4;

  for (genvar i = 0; i < CODE_BYTES; i++) begin : g_raw
    if (i < rcrf_pkg::IN_BYTES) begin : g_in
      assign raw[i] = in_bytes[i];
    end else begin : g_pad
      assign raw[i] = 8'h00;
    end
  end

  always_comb begin
    last_raw = 8'h00;
    for (int i = 0; i < CODE_BYTES; i++) begin
      if (in_data.byte_count == rcrf_pkg::LEN_W'(i + 1)) begin
        last_raw = raw[i];
      end
    end
  end

  assign chan = (remote_kind_r == rcrf_pkg::KIND_FIRST_BYTE) ? in_data.byte0
                                                             : {4'h0, last_raw[7:4]};

  assign ctrl.len          = in_data.byte_count;
  assign ctrl.strip_nibble = !unique_codes_r && (remote_kind_r == rcrf_pkg::KIND_NIBBLE);
  assign ctrl.strip_first  = !unique_codes_r && (remote_kind_r == rcrf_pkg::KIND_FIRST_BYTE);
  assign ctrl.chan_nibble  = last_raw[7:4];

  for (genvar i = 0; i < CODE_BYTES; i++) begin : g_lane
    rcrf_lane #(
      .LANE_IDX(i)
    ) u_lane (
      .ctrl        (ctrl),
      .raw_byte    (raw[i]),
      .stored_byte (last_code_r[i]),
      .wr_byte     (wr_bytes[i]),
      .match       (lane_match[i])
    );
    assign next_code[i] = stat.same ? last_code_r[i] : wr_bytes[i];
  end

  rcrf_merge #(
    .CODE_BYTES     (CODE_BYTES),
    .MIN_CODE_BYTES (MIN_CODE_BYTES)
  ) u_merge (
    .packet_ok     (in_data.packet_ok),
    .len           (in_data.byte_count),
    .chan          (chan),
    .channel_mask  (channel_mask_r),
    .lane_match    (lane_match),
    .now           (in_data.now),
    .last_time     (last_time_r),
    .repeat_window (repeat_window_r),
    .stat          (stat)
  );

  for (genvar i = 0; i < rcrf_pkg::IN_BYTES; i++) begin : g_res
    if (i < CODE_BYTES) begin : g_code
      assign res_bytes[i] = next_code[i];
    end else begin : g_zero
      assign res_bytes[i] = 8'h00;
    end
  end

  assign result.out_byte0 = res_bytes[0];
  assign result.out_byte1 = res_bytes[1];
  assign result.out_byte2 = res_bytes[2];
  assign result.out_byte3 = res_bytes[3];
  assign result.out_byte4 = res_bytes[4];
  assign result.channel   = chan;

  assign in_stall  = skid_valid_r;
  assign accept    = in_valid && !skid_valid_r;
  assign res_valid = accept && stat.emit;
  assign out_take  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_mask_r  <= rcrf_pkg::CHANNEL_MASK_RST;
      unique_codes_r  <= 1'b0;
      repeat_window_r <= rcrf_pkg::REPEAT_WINDOW_RST;
      remote_kind_r   <= rcrf_pkg::KIND_NIBBLE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rcrf_pkg::CFG_CHANNEL_MASK:  channel_mask_r  <= cfg_wdata;
        rcrf_pkg::CFG_UNIQUE_CODES:  unique_codes_r  <= cfg_wdata[0];
        rcrf_pkg::CFG_REPEAT_WINDOW: repeat_window_r <= cfg_wdata[15:0];
        rcrf_pkg::CFG_REMOTE_KIND:   remote_kind_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CODE_BYTES; i++) begin
        last_code_r[i] <= 8'h00;
      end
      last_time_r <= '0;
    end else if (res_valid) begin
      last_time_r <= in_data.now;
      for (int i = 0; i < CODE_BYTES; i++) begin
        last_code_r[i] <= next_code[i];
      end
    end
  end

  // The skid entry catches a result that arrives while the output is held.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_take) begin
      out_data_r <= skid_valid_r ? skid_data_r : result;
    end
    if (out_valid_r && !out_take && res_valid) begin
      skid_data_r <= result;
    end
  end

endmodule

// ===== sv/rcrf_lane.sv =====
module rcrf_lane #(
  parameter int LANE_IDX = 0
) (
  input  rcrf_pkg::lane_ctrl_t ctrl,
  input  logic [7:0]           raw_byte,
  input  logic [7:0]           stored_byte,
  output logic [7:0]           wr_byte,
  output logic                 match
);

  logic       in_len;
  logic [7:0] code_byte;

  assign in_len = ctrl.len > rcrf_pkg::LEN_W'(LANE_IDX);

  always_comb begin
    code_byte = raw_byte;
    if (ctrl.strip_nibble) begin
      if (ctrl.len == rcrf_pkg::LEN_W'(LANE_IDX + 1)) begin
        code_byte = raw_byte & rcrf_pkg::LOW_NIBBLE_MASK;
      end else if (ctrl.len >= rcrf_pkg::LEN_W'(3) &&
                   ctrl.len == rcrf_pkg::LEN_W'(LANE_IDX + 3)) begin
        code_byte = raw_byte - {ctrl.chan_nibble, 4'h0};
      end
    end
    if (ctrl.strip_first && LANE_IDX == 0) begin
      code_byte = 8'h00;
    end
  end

  // Bytes past the packet length do not take part in the compare and are
  // written back as zero when a new code is stored.
  assign match   = !in_len || (code_byte == stored_byte);
  assign wr_byte = in_len ? code_byte : 8'h00;

endmodule

// ===== sv/rcrf_merge.sv =====
module rcrf_merge #(
  parameter int CODE_BYTES     = rcrf_pkg::CODE_BYTES_DEF,
  parameter int MIN_CODE_BYTES = rcrf_pkg::MIN_CODE_BYTES_DEF
) (
  input  logic                         packet_ok,
  input  logic [rcrf_pkg::LEN_W-1:0]   len,
  input  logic [7:0]                   chan,
  input  logic [31:0]                  channel_mask,
  input  logic [CODE_BYTES-1:0]        lane_match,
  input  logic [31:0]                  now,
  input  logic [31:0]                  last_time,
  input  logic [15:0]                  repeat_window,
  output rcrf_pkg::merge_stat_t        stat
);

  logic        len_ok;
  logic        chan_ok;
  logic        same;
  logic [31:0] elapsed;
  logic        in_window;

  assign len_ok = (len >= rcrf_pkg::LEN_W'(MIN_CODE_BYTES)) &&
                  (len <= rcrf_pkg::LEN_W'(CODE_BYTES)) && (len != '0);
  assign chan_ok   = (chan[7:5] == 3'd0) && channel_mask[chan[4:0]];
  assign same      = &lane_match;
  // Modular difference keeps the window test correct across timer wrap.
  assign elapsed   = now - last_time;
  assign in_window = elapsed < {16'h0000, repeat_window};

  assign stat.same = same;
  assign stat.emit = packet_ok && len_ok && chan_ok && !(same && in_window);

endmodule

// ===== sim/repeat_filter_checker.sv =====
`timescale 1ns / 1ps

module repeat_filter_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  rcrf_pkg::in_item_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  rcrf_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [rcrf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                     cfg_wdata,
  output int                              fail_count,
  output int                              pending_count
);

  logic [31:0] mask_q;
  logic        unique_q;
  logic [15:0] window_q;
  logic        kind_q;

  logic [7:0]  stored_code [rcrf_pkg::IN_BYTES];
  logic [31:0] stored_time;

  rcrf_pkg::out_item_t expected_codes [$];

  // Applies one packet to the stored code and time; returns 1 when the
  // packet produces a result.
  function automatic bit filter_code(input rcrf_pkg::in_item_t pkt,
                                     output rcrf_pkg::out_item_t res);
    logic [7:0] code [rcrf_pkg::IN_BYTES];
    logic [7:0] chan;
    int         len;
    bit         same;
    res = '0;
    len = int'(pkt.byte_count);
    if (!pkt.packet_ok) return 0;
    if (len < rcrf_pkg::MIN_CODE_BYTES_DEF || len > rcrf_pkg::CODE_BYTES_DEF) return 0;
    code = '{pkt.byte0, pkt.byte1, pkt.byte2, pkt.byte3, pkt.byte4};
    if (kind_q == rcrf_pkg::KIND_NIBBLE) begin
      chan = {4'h0, code[len-1][7:4]};
      if (!unique_q) begin
        code[len-1] = code[len-1] & rcrf_pkg::LOW_NIBBLE_MASK;
        // The channel also sits in the high nibble two bytes earlier.
        if (len >= 3) code[len-3] = code[len-3] - {chan[3:0], 4'h0};
      end
    end else begin
      chan = code[0];
      if (!unique_q) code[0] = 8'h00;
    end
    if (chan >= 8'd32) return 0;
    if (!mask_q[chan[4:0]]) return 0;
    same = 1'b1;
    for (int i = 0; i < len; i++)
      if (stored_code[i] != code[i]) same = 1'b0;
    if (same) begin
      if (pkt.now - stored_time < {16'h0000, window_q}) return 0;
    end else begin
      // A matching code leaves the bytes past its length as they were.
      for (int i = 0; i < rcrf_pkg::IN_BYTES; i++)
        stored_code[i] = (i < len) ? code[i] : 8'h00;
    end
    stored_time = pkt.now;
    res = '{stored_code[0], stored_code[1], stored_code[2], stored_code[3],
            stored_code[4], chan};
    return 1;
  endfunction

  function automatic int field_diff(input string name, input logic [7:0] want_v,
                                    input logic [7:0] got_v);
    if (got_v === want_v) return 0;
    $error("%s mismatch: expected 0x%02h, actual 0x%02h", name, want_v, got_v);
    return 1;
  endfunction

  always @(posedge clk) begin : watch
    rcrf_pkg::out_item_t want;
    rcrf_pkg::out_item_t fresh;
    if (!rst_n) begin
      mask_q   = rcrf_pkg::CHANNEL_MASK_RST;
      unique_q = 1'b0;
      window_q = rcrf_pkg::REPEAT_WINDOW_RST;
      kind_q   = rcrf_pkg::KIND_NIBBLE;
      foreach (stored_code[i]) stored_code[i] = 8'h00;
      stored_time = '0;
      expected_codes.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_codes.size() == 0) begin
          $error("unexpected result transaction: channel 0x%02h, nothing pending",
                 out_data.channel);
          fail_count++;
        end else begin
          want = expected_codes.pop_front();
          fail_count += field_diff("out_byte0", want.out_byte0, out_data.out_byte0)
                      + field_diff("out_byte1", want.out_byte1, out_data.out_byte1)
                      + field_diff("out_byte2", want.out_byte2, out_data.out_byte2)
                      + field_diff("out_byte3", want.out_byte3, out_data.out_byte3)
                      + field_diff("out_byte4", want.out_byte4, out_data.out_byte4)
                      + field_diff("channel", want.channel, out_data.channel);
        end
      end
      // A packet taken at the same edge as a register write still sees the old setup.
      if (in_valid && !in_stall) begin
        if (filter_code(in_data, fresh)) expected_codes.push_back(fresh);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rcrf_pkg::CFG_CHANNEL_MASK:  mask_q   = cfg_wdata;
          rcrf_pkg::CFG_UNIQUE_CODES:  unique_q = cfg_wdata[0];
          rcrf_pkg::CFG_REPEAT_WINDOW: window_q = cfg_wdata[15:0];
          rcrf_pkg::CFG_REMOTE_KIND:   kind_q   = cfg_wdata[0];
          default: ;
        endcase
      end
    end
    pending_count <= expected_codes.size();
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int LIMIT = 200000;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  rcrf_pkg::in_item_t             in_data   = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  rcrf_pkg::out_item_t            out_data;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [rcrf_pkg::CFG_IDX_W-1:0] cfg_index = rcrf_pkg::CFG_CHANNEL_MASK;
  logic [31:0]                    cfg_wdata = '0;

  int fail_count;
  int pending_count;
  int cycles    = 0;
  int idle_pct  = 0;
  int stall_pct = 0;

  // Stimulus shaping state: arrival clock, last fresh packet, current setup.
  logic [31:0]        tick       = '0;
  rcrf_pkg::in_item_t prev_pkt   = '0;
  bit                 have_prev  = 1'b0;
  logic [31:0]        cur_window = 32'd10;
  logic               cur_kind   = rcrf_pkg::KIND_NIBBLE;

  always #4 clk = ~clk;

  remote_code_channel_repeat_filter_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  repeat_filter_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic rcrf_pkg::in_item_t make_packet(input logic ok, input logic [5:0] len,
                                           input logic [7:0] b0, input logic [7:0] b1,
                                           input logic [7:0] b2, input logic [7:0] b3,
                                           input logic [7:0] b4, input logic [31:0] at);
    return '{ok, len, b0, b1, b2, b3, b4, at};
  endfunction

  // Advances the arrival clock, favoring steps right around the repeat window.
  function automatic logic [31:0] next_arrival();
    logic [31:0] delta;
    case ($urandom_range(5))
      0:       delta = $urandom_range(3);
      1:       delta = cur_window - 1;
      2:       delta = cur_window;
      3:       delta = cur_window + 1;
      4:       delta = $urandom_range(65535);
      default: delta = $urandom;
    endcase
    tick = tick + delta;
    return tick;
  endfunction

  function automatic rcrf_pkg::in_item_t random_packet();
    rcrf_pkg::in_item_t it;
    int                 r;
    r = $urandom_range(99);
    if (r < 12) begin
      it.packet_ok  = 1'($urandom_range(1));
      it.byte_count = 6'($urandom_range(63));
      it.byte0      = 8'($urandom_range(255));
      it.byte1      = 8'($urandom_range(255));
      it.byte2      = 8'($urandom_range(255));
      it.byte3      = 8'($urandom_range(255));
      it.byte4      = 8'($urandom_range(255));
      it.now        = $urandom;
    end else if (r < 45 && have_prev) begin
      // Resend the last code so the repeat window gets exercised.
      it = prev_pkt;
      it.packet_ok = 1'b1;
      if ($urandom_range(3) == 0) it.byte_count = 6'($urandom_range(5, 3));
      it.now = next_arrival();
    end else begin
      it.packet_ok  = ($urandom_range(19) != 0);
      it.byte_count = 6'($urandom_range(5, 3));
      it.byte0      = 8'($urandom_range(255));
      it.byte1      = 8'($urandom_range(255));
      it.byte2      = 8'($urandom_range(255));
      it.byte3      = 8'($urandom_range(255));
      it.byte4      = 8'($urandom_range(255));
      if (cur_kind == rcrf_pkg::KIND_FIRST_BYTE)
        it.byte0 = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                            : 8'($urandom_range(40));
      it.now    = next_arrival();
      prev_pkt  = it;
      have_prev = 1'b1;
    end
    return it;
  endfunction

  task automatic drive_item(input rcrf_pkg::in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // Holds off the sender until every pending result has come out.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rcrf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] val);
    cfg_index <= idx;
    cfg_wdata <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input logic [31:0] mask, input logic uniq,
                           input logic [15:0] win, input logic kind);
    logic [31:0] junk;
    junk = $urandom;
    // Unused upper bits carry noise; the registers must ignore them.
    write_reg(rcrf_pkg::CFG_CHANNEL_MASK, mask);
    write_reg(rcrf_pkg::CFG_UNIQUE_CODES, {junk[31:1], uniq});
    write_reg(rcrf_pkg::CFG_REPEAT_WINDOW, {junk[15:0], win});
    write_reg(rcrf_pkg::CFG_REMOTE_KIND, {junk[30:0], kind});
    cfg_valid  <= 1'b0;
    cur_window = {16'h0000, win};
    cur_kind   = kind;
  endtask

  task automatic run_directed();
    // Reset setup: mask 0xFFFF, channel stripped, window 10, channel in nibble.
    drive_item(make_packet(1'b0, 6'd3, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 32'd100));
    drive_item(make_packet(1'b1, 6'd0, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 32'd100));
    drive_item(make_packet(1'b1, 6'd2, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 32'd100));
    drive_item(make_packet(1'b1, 6'd6, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 32'd100));
    drive_item(make_packet(1'b1, 6'd63, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF));
    // All-zero code equals the cleared store: inside, then at the window edge.
    drive_item(make_packet(1'b1, 6'd3, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 32'd5));
    drive_item(make_packet(1'b1, 6'd3, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 32'd10));
    // Channel 15 with a borrow in the stripped byte.
    drive_item(make_packet(1'b1, 6'd5, 8'h12, 8'h34, 8'h05, 8'h06, 8'hF9, 32'd20));
    drive_item(make_packet(1'b1, 6'd5, 8'h12, 8'h34, 8'h05, 8'h06, 8'hF9, 32'd29));
    drive_item(make_packet(1'b1, 6'd5, 8'h12, 8'h34, 8'h05, 8'h06, 8'hF9, 32'd30));
    // Shorter code matching the stored prefix keeps the stored tail.
    drive_item(make_packet(1'b1, 6'd4, 8'h12, 8'h54, 8'h15, 8'h26, 8'hEE, 32'd200));
    drive_item(make_packet(1'b1, 6'd4, 8'h00, 8'hFF, 8'h80, 8'h0C, 8'h00, 32'd300));
    // Repeat window across the wrap of the arrival clock.
    drive_item(make_packet(1'b1, 6'd3, 8'h01, 8'h02, 8'h03, 8'h00, 8'h00, 32'hFFFF_FFFC));
    drive_item(make_packet(1'b1, 6'd3, 8'h01, 8'h02, 8'h03, 8'h00, 8'h00, 32'd3));
    drive_item(make_packet(1'b1, 6'd3, 8'h01, 8'h02, 8'h03, 8'h00, 8'h00, 32'd6));
    drain();
    // Channel in the first byte: range limit and mask.
    configure(32'h8000_0001, 1'b0, 16'd0, rcrf_pkg::KIND_FIRST_BYTE);
    drive_item(make_packet(1'b1, 6'd3, 8'd0, 8'h10, 8'h20, 8'h30, 8'h40, 32'd400));
    drive_item(make_packet(1'b1, 6'd5, 8'd31, 8'h10, 8'h20, 8'h30, 8'h40, 32'd401));
    drive_item(make_packet(1'b1, 6'd5, 8'd32, 8'h10, 8'h20, 8'h30, 8'h40, 32'd402));
    drive_item(make_packet(1'b1, 6'd4, 8'd255, 8'h10, 8'h20, 8'h30, 8'h40, 32'd403));
    drive_item(make_packet(1'b1, 6'd4, 8'd1, 8'h10, 8'h20, 8'h30, 8'h40, 32'd404));
    drain();
    // Channel kept in the code, widest window.
    configure(32'hFFFF_FFFF, 1'b1, 16'hFFFF, rcrf_pkg::KIND_NIBBLE);
    drive_item(make_packet(1'b1, 6'd5, 8'hAA, 8'hBB, 8'hCC, 8'hDD, 8'hF9, 32'd1000));
    drive_item(make_packet(1'b1, 6'd5, 8'hAA, 8'hBB, 8'hCC, 8'hDD, 8'hF9, 32'd66534));
    drive_item(make_packet(1'b1, 6'd5, 8'hAA, 8'hBB, 8'hCC, 8'hDD, 8'hF9, 32'd66535));
    drain();
  endtask

  task automatic setup_phase(input int p);
    case (p)
      0: configure(32'hFFFF_FFFF, 1'b0, 16'd10, rcrf_pkg::KIND_NIBBLE);
      1: configure($urandom, 1'b1, 16'd0, rcrf_pkg::KIND_NIBBLE);
      2: configure(32'hFFFF_FFFF, 1'b0, 16'hFFFF, rcrf_pkg::KIND_FIRST_BYTE);
      3: configure(32'h0000_0000, 1'b0, 16'd5, rcrf_pkg::KIND_NIBBLE);
      4: configure($urandom | 32'h1, 1'b1, 16'd3, rcrf_pkg::KIND_FIRST_BYTE);
      5: configure(32'h0000_FFFF, 1'b0, 16'd100, rcrf_pkg::KIND_NIBBLE);
      6: configure(32'hFFFF_FFFF, 1'b1, 16'd1, rcrf_pkg::KIND_FIRST_BYTE);
      default: configure($urandom, 1'b0, 16'($urandom_range(65535)), rcrf_pkg::KIND_NIBBLE);
    endcase
    case (p % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 79; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 79; end
      default: begin idle_pct = 31; stall_pct = 31; end
    endcase
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    for (int p = 0; p < 8; p++) begin
      setup_phase(p);
      // With every channel masked off nothing comes out, so keep it short.
      repeat ((p == 3) ? 60 : 250) drive_item(random_packet());
      drain();
    end
    if (fail_count == 0 && pending_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
